@@ sv/rope_pkg.sv @@
package rope_pkg;

  typedef struct packed {
    logic [15:0] x_first;
    logic [15:0] x_second;
    logic [31:0] cos_bits;
    logic [31:0] sin_bits;
    logic        last_pair;
  } rope_in_t;

  typedef struct packed {
    logic [15:0] y_first;
    logic [15:0] y_second;
    logic        last_out;
  } rope_out_t;

  localparam logic [15:0] BF16_QNAN = 16'h7FC0;
  localparam logic [31:0] F32_QNAN  = 32'h7FC00000;

  // Classification of an FP32 operand.
  typedef struct packed {
    logic       sign;
    logic       is_nan;
    logic       is_inf;
    logic       is_zero;
    logic [9:0] exp;   // unbiased plus 127, subnormals use 1
    logic [23:0] man;  // with hidden bit
  } rope_fp_t;

  function automatic rope_fp_t fp_unpack(input logic [31:0] v);
    rope_fp_t r;
    r.sign    = v[31];
    r.is_nan  = (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
    r.is_inf  = (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
    r.is_zero = (v[30:0] == 31'd0);
    r.exp     = (v[30:23] == 8'd0) ? 10'd1 : {2'b00, v[30:23]};
    r.man     = {(v[30:23] != 8'd0), v[22:0]};
    return r;
  endfunction

  // Count leading zeros of a 50-bit vector.
  function automatic logic [5:0] clz50(input logic [49:0] v);
    logic [5:0] n;
    logic       found;
    n = 6'd50;
    found = 1'b0;
    for (int k = 49; k >= 0; k--) begin
      if (!found && v[k]) begin
        n = 6'(49 - k);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // Round a normalized-left magnitude to FP32, nearest even.
  // mag has its leading one at bit 49 or is zero; e is the exponent of bit 49
  // with bias 127, as a signed value.
  function automatic logic [31:0] fp_round(input logic sign, input logic signed [11:0] e,
                                           input logic [49:0] mag);
    logic [49:0] m;
    logic signed [11:0] ex;
    logic [11:0] sh;
    logic        sticky;
    logic [24:0] kept;
    logic        g;
    logic        st;
    logic [24:0] rnd;
    logic [31:0] r;
    m = mag;
    ex = e;
    sticky = 1'b0;
    // Denormalize when below the normal range.
    if (ex < 12'sd1) begin
      sh = 12'(12'sd1 - ex);
      if (sh > 12'd50) begin
        sticky = |m;
        m = 50'd0;
      end else begin
        for (int k = 0; k < 50; k++) begin
          if (12'(k) < sh) sticky = sticky | m[k];
        end
        m = m >> sh;
      end
      ex = 12'sd0;
    end
    kept = {1'b0, m[49:26]};
    g    = m[25];
    st   = (|m[24:0]) | sticky;
    rnd  = kept + 25'(g & (st | kept[0]));
    if (rnd[24]) begin
      rnd = rnd >> 1;
      ex  = ex + 12'sd1;
    end else if (ex == 12'sd0 && rnd[23]) begin
      ex = 12'sd1;
    end
    if (ex >= 12'sd255) begin
      r = {sign, 8'hFF, 23'd0};
    end else begin
      r = {sign, ex[7:0], rnd[22:0]};
    end
    return r;
  endfunction

  function automatic logic [15:0] f32_to_bf16(input logic [31:0] u);
    logic [31:0] t;
    if (u[30:23] == 8'hFF && u[22:0] != 23'd0) begin
      return BF16_QNAN;
    end
    t = u + 32'h7FFF + {31'd0, u[16]};
    return t[31:16];
  endfunction

endpackage

@@ sv/rope_mul.sv @@
// Two-stage FP32 multiplier: mantissa product registered, then rounding.
module rope_mul import rope_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] p
);
  rope_fp_t fa, fb;
  logic [47:0] prod_nxt;
  logic [47:0] prod_r;
  logic signed [11:0] e_r, e_nxt;
  logic sign_r, nan_r, inf_r;
  logic sign_nxt, nan_nxt, inf_nxt;
  logic [5:0] lz;
  logic [49:0] norm;
  logic [31:0] p_nxt;
  logic [31:0] p_r;

  // Unpack and multiply mantissas.
  always_comb begin
    fa = fp_unpack(a);
    fb = fp_unpack(b);
    prod_nxt = fa.man * fb.man;
    sign_nxt = fa.sign ^ fb.sign;
    nan_nxt  = fa.is_nan | fb.is_nan | (fa.is_inf & fb.is_zero) | (fb.is_inf & fa.is_zero);
    inf_nxt  = fa.is_inf | fb.is_inf;
    // Bit 47 of the product weighs 2^(ea+eb-254+1).
    e_nxt    = $signed({2'b00, fa.exp}) + $signed({2'b00, fb.exp}) - 12'sd126;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      e_r    <= e_nxt;
      sign_r <= sign_nxt;
      nan_r  <= nan_nxt;
      inf_r  <= inf_nxt;
    end
  end

  // Normalize and round.
  always_comb begin
    lz   = clz50({prod_r, 2'b00});
    norm = {prod_r, 2'b00} << lz;
    if (nan_r) begin
      p_nxt = F32_QNAN;
    end else if (inf_r) begin
      p_nxt = {sign_r, 8'hFF, 23'd0};
    end else if (prod_r == 48'd0) begin
      p_nxt = {sign_r, 31'd0};
    end else begin
      p_nxt = fp_round(sign_r, e_r - $signed({6'd0, lz}), norm);
    end
  end

  always_ff @(posedge clk) begin
    if (en) p_r <= p_nxt;
  end
  assign p = p_r;
endmodule

@@ sv/rope_add.sv @@
// Two-stage FP32 adder: align and add registered, then normalize and round.
module rope_add import rope_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic        sub,
  output logic [31:0] s
);
  rope_fp_t fa, fb, big, sml;
  logic [31:0] bb;
  logic swap;
  logic [9:0] d;
  logic [49:0] mb, ms;
  logic sticky;
  logic [50:0] sum_nxt, sum_r;
  logic signed [11:0] e_r;
  logic sign_r, nan_r, inf_r, infs_r, zz_r, zsign_r;
  logic [5:0] lz;
  logic [50:0] norm;
  logic [31:0] s_nxt;
  logic [31:0] s_r;

  always_comb begin
    bb = {b[31] ^ sub, b[30:0]};
    fa = fp_unpack(a);
    fb = fp_unpack(bb);
    swap = {fb.exp, fb.man} > {fa.exp, fa.man};
    big = swap ? fb : fa;
    sml = swap ? fa : fb;
    d = big.exp - sml.exp;
    mb = {big.man, 26'd0};
    ms = {sml.man, 26'd0};
    sticky = 1'b0;
    if (d > 10'd49) begin
      sticky = |ms;
      ms = 50'd0;
    end else begin
      for (int k = 0; k < 50; k++) begin
        if (10'(k) < d) sticky = sticky | ms[k];
      end
      ms = ms >> d;
    end
    ms[0] = ms[0] | sticky;
    if (big.sign == sml.sign) sum_nxt = {1'b0, mb} + {1'b0, ms};
    else                      sum_nxt = {1'b0, mb} - {1'b0, ms};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r   <= sum_nxt;
      e_r     <= $signed({2'b00, big.exp}) + 12'sd1;
      sign_r  <= big.sign;
      nan_r   <= fa.is_nan | fb.is_nan | (fa.is_inf & fb.is_inf & (fa.sign != fb.sign));
      inf_r   <= fa.is_inf | fb.is_inf;
      infs_r  <= fa.is_inf ? fa.sign : fb.sign;
      zz_r    <= fa.is_zero & fb.is_zero;
      zsign_r <= fa.sign & fb.sign;
    end
  end

  always_comb begin
    lz   = clz50(sum_r[50:1]);
    norm = sum_r << lz;
    if (nan_r) begin
      s_nxt = F32_QNAN;
    end else if (inf_r) begin
      s_nxt = {infs_r, 8'hFF, 23'd0};
    end else if (zz_r) begin
      s_nxt = {zsign_r, 31'd0};
    end else if (sum_r == 51'd0) begin
      s_nxt = 32'd0;
    end else begin
      // Sticky bit 0 stays below the round position.
      s_nxt = fp_round(sign_r, e_r - $signed({6'd0, lz}), norm[50:1] | {49'd0, norm[0]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) s_r <= s_nxt;
  end
  assign s = s_r;
endmodule

@@ sv/rope_rotate_bf16.sv @@
// Rotates one half-split rotary pair per word: y_first = a*cos - b*sin and
// y_second = b*cos + a*sin, products and sums rounded to FP32 and results to
// BF16, nearest even, NaN given as 0x7FC0. One word enters per cycle while the
// pipeline is not stalled; the stages are two multiplier stages, two adder
// stages and the BF16 output register. The whole pipeline advances when the
// output register is empty or taken, so a stall holds every stage.
module rope_rotate_bf16 import rope_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  rope_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output rope_out_t out_data
);
  localparam int Depth = 5;

  logic [Depth-1:0] vld_r, vld_nxt;
  logic [Depth-1:0] last_r;
  logic [15:0] y_first_r, y_second_r;
  logic en;
  logic [31:0] a32, b32, ac, bs, bc, as_p, y1, y2;

  assign en        = !vld_r[Depth-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[Depth-1];
  assign a32 = {in_data.x_first, 16'd0};
  assign b32 = {in_data.x_second, 16'd0};

  rope_mul u_ac (.clk, .en, .a(a32), .b(in_data.cos_bits), .p(ac));
  rope_mul u_bs (.clk, .en, .a(b32), .b(in_data.sin_bits), .p(bs));
  rope_mul u_bc (.clk, .en, .a(b32), .b(in_data.cos_bits), .p(bc));
  rope_mul u_as (.clk, .en, .a(a32), .b(in_data.sin_bits), .p(as_p));
  rope_add u_y1 (.clk, .en, .a(ac), .b(bs), .sub(1'b1), .s(y1));
  rope_add u_y2 (.clk, .en, .a(bc), .b(as_p), .sub(1'b0), .s(y2));

  // Valid bits shift with the data.
  assign vld_nxt = {vld_r[Depth-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // Flag and output register.
  always_ff @(posedge clk) begin
    if (en) begin
      last_r     <= {last_r[Depth-2:0], in_data.last_pair};
      y_first_r  <= f32_to_bf16(y1);
      y_second_r <= f32_to_bf16(y2);
    end
  end

  assign out_data = '{y_first: y_first_r, y_second: y_second_r, last_out: last_r[Depth-1]};

`ifndef SYNTHESIS
  // A held result must not change.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
  // Ready follows the output stage.
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");
  // An accepted word reaches the output after the pipeline depth when never stalled.
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && en ##1 en ##1 en ##1 en ##1 en |=> out_valid)
    else $error("word lost in pipeline");
`endif
endmodule

@@ bench/tb_rope_rotate_bf16.sv @@
module tb_rope_rotate_bf16;
  import rope_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  rope_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  rope_out_t out_data;

  rope_out_t pending_rot[$];
  int        fail_count = 0;
  int        words_sent = 0;
  int        words_checked = 0;
  int        tx_gap_max = 0;
  int        rx_gap_max = 0;

  localparam logic [31:0] F32_ONE     = 32'h3F800000;
  localparam logic [31:0] F32_NEG_ONE = 32'hBF800000;
  localparam logic [31:0] F32_PINF    = 32'h7F800000;
  localparam logic [15:0] BF_PINF     = 16'h7F80;
  localparam logic [15:0] BF_NINF     = 16'hFF80;
  localparam logic [15:0] BF_MAX      = 16'h7F7F;
  localparam logic [15:0] BF_NZERO    = 16'h8000;

  rope_rotate_bf16 DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Rounds sign * mag * 2^scale to an FP32 pattern, nearest even, with
  // gradual underflow and overflow to infinity.
  function automatic logic [31:0] round_to_f32(input logic sgn, input longint unsigned mag,
                                               input int scale);
    int msb;
    int biased;
    int shift;
    longint unsigned kept;
    longint unsigned rem;
    longint unsigned half;
    longint unsigned bits;
    msb = -1;
    if (mag == 0) begin
      return {sgn, 31'd0};
    end
    for (int k = 63; k >= 0; k--) begin
      if (msb < 0 && mag[k]) msb = k;
    end
    biased = msb + scale + 127;
    shift = (biased >= 1) ? msb - 23 : -149 - scale;
    if (shift > 62) begin
      kept = 0;
    end else if (shift > 0) begin
      kept = mag >> shift;
      rem  = mag & ((64'd1 << shift) - 1);
      half = 64'd1 << (shift - 1);
      if (rem > half || (rem == half && kept[0])) kept = kept + 1;
    end else begin
      kept = mag << (-shift);
    end
    // A carry out of the mantissa moves into the exponent field by itself.
    if (biased >= 1) bits = (longint'(biased - 1) << 23) + kept;
    else bits = kept;
    if (bits >= 64'h7F800000) bits = 64'h7F800000;
    return {sgn, bits[30:0]};
  endfunction

  function automatic logic f32_is_nan(input logic [31:0] v);
    return (v[30:23] == 8'hFF) && (v[22:0] != 0);
  endfunction

  function automatic logic f32_is_inf(input logic [31:0] v);
    return (v[30:23] == 8'hFF) && (v[22:0] == 0);
  endfunction

  function automatic logic [31:0] f32_mul(input logic [31:0] x, input logic [31:0] y);
    logic sgn;
    int ex;
    int ey;
    longint unsigned mx;
    longint unsigned my;
    sgn = x[31] ^ y[31];
    if (f32_is_nan(x) || f32_is_nan(y)) return F32_QNAN;
    if (f32_is_inf(x) || f32_is_inf(y)) begin
      if (x[30:0] == 0 || y[30:0] == 0) return F32_QNAN;
      return {sgn, F32_PINF[30:0]};
    end
    ex = (x[30:23] == 0) ? 1 : int'(x[30:23]);
    ey = (y[30:23] == 0) ? 1 : int'(y[30:23]);
    mx = {40'd0, (x[30:23] != 0), x[22:0]};
    my = {40'd0, (y[30:23] != 0), y[22:0]};
    return round_to_f32(sgn, mx * my, ex + ey - 300);
  endfunction

  function automatic logic [31:0] f32_add(input logic [31:0] x, input logic [31:0] y);
    int ex;
    int ey;
    int d;
    longint unsigned mx;
    longint unsigned my;
    longint unsigned lost;
    if (f32_is_nan(x) || f32_is_nan(y)) return F32_QNAN;
    if (f32_is_inf(x) && f32_is_inf(y) && x[31] != y[31]) return F32_QNAN;
    if (f32_is_inf(x)) return x;
    if (f32_is_inf(y)) return y;
    if (x[30:0] == 0 && y[30:0] == 0) return {x[31] & y[31], 31'd0};
    ex = (x[30:23] == 0) ? 1 : int'(x[30:23]);
    ey = (y[30:23] == 0) ? 1 : int'(y[30:23]);
    // Thirty spare low bits keep the guard and sticky information exact.
    mx = {40'd0, (x[30:23] != 0), x[22:0]} << 30;
    my = {40'd0, (y[30:23] != 0), y[22:0]} << 30;
    if (ex < ey) begin
      d = ey - ex;
      if (d >= 60) mx = (mx != 0);
      else begin
        lost = mx & ((64'd1 << d) - 1);
        mx = (mx >> d) | (lost != 0);
      end
      ex = ey;
    end else if (ey < ex) begin
      d = ex - ey;
      if (d >= 60) my = (my != 0);
      else begin
        lost = my & ((64'd1 << d) - 1);
        my = (my >> d) | (lost != 0);
      end
    end
    if (x[31] == y[31]) return round_to_f32(x[31], mx + my, ex - 180);
    if (mx == my) return 32'd0;
    if (mx > my) return round_to_f32(x[31], mx - my, ex - 180);
    return round_to_f32(y[31], my - mx, ex - 180);
  endfunction

  function automatic logic [15:0] narrow_to_bf16(input logic [31:0] v);
    logic [31:0] biased_up;
    if (f32_is_nan(v)) return BF16_QNAN;
    biased_up = v + 32'h00007FFF + 32'(v[16]);
    return biased_up[31:16];
  endfunction

  function automatic rope_out_t rotate_pair_expect(input rope_in_t w);
    rope_out_t r;
    logic [31:0] a;
    logic [31:0] b;
    a = {w.x_first, 16'd0};
    b = {w.x_second, 16'd0};
    r.y_first  = narrow_to_bf16(f32_add(f32_mul(a, w.cos_bits),
                                        f32_mul(b, w.sin_bits) ^ 32'h80000000));
    r.y_second = narrow_to_bf16(f32_add(f32_mul(b, w.cos_bits), f32_mul(a, w.sin_bits)));
    r.last_out = w.last_pair;
    return r;
  endfunction

  // Sends one word after a random gap and records its expected rotation.
  task automatic send_pair(input rope_in_t w);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    pending_rot.push_back(rotate_pair_expect(w));
    words_sent++;
  endtask

  task automatic send_fields(input logic [15:0] a, input logic [15:0] b,
                             input logic [31:0] c, input logic [31:0] s, input logic l);
    rope_in_t w;
    w.x_first = a; w.x_second = b; w.cos_bits = c; w.sin_bits = s; w.last_pair = l;
    send_pair(w);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_rot.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_bf16();
    case ($urandom_range(0, 9))
      0: return {1'($urandom), 15'($urandom_range(0, 16'h7F))};  // zero or subnormal
      1: return {1'($urandom), BF_PINF[14:0]};
      2: return {1'($urandom), 8'hFF, 7'($urandom_range(1, 127))};
      3: return {1'($urandom), 8'($urandom_range(250, 254)), 7'($urandom)};
      4, 5: return 16'($urandom);
      default: return {1'($urandom), 8'($urandom_range(110, 140)), 7'($urandom)};
    endcase
  endfunction

  function automatic logic [31:0] pick_trig();
    case ($urandom_range(0, 9))
      0: return {1'($urandom), 31'($urandom_range(0, 32'h7FFFFF))};
      1: return $urandom_range(0, 1) ? F32_ONE : F32_NEG_ONE;
      2: return {1'($urandom), 8'hFF, 23'($urandom_range(0, 3))};
      3, 4: return $urandom;
      default: return {1'($urandom), 8'($urandom_range(100, 126)), 23'($urandom)};
    endcase
  endfunction

  // Boundary values and every special case, no idling.
  task automatic test_directed();
    tx_gap_max = 0; rx_gap_max = 0;
    send_fields(16'h0000, 16'h0000, 32'h0, 32'h0, 1'b0);             // +0 - +0
    send_fields(BF_NZERO, 16'h0000, F32_ONE, F32_ONE, 1'b1);          // signed zeros
    send_fields(BF_NZERO, 16'h0000, F32_ONE, 32'h0, 1'b0);
    send_fields(16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1); // NaN operands
    send_fields(16'h7F81, 16'h3F80, F32_ONE, F32_ONE, 1'b0);
    send_fields(BF_PINF, BF_PINF, F32_ONE, F32_ONE, 1'b0);             // inf - inf
    send_fields(BF_PINF, 16'h3F80, 32'h0, 32'h0, 1'b1);                // zero times inf
    send_fields(BF_NINF, 16'h3F80, F32_ONE, F32_NEG_ONE, 1'b0);
    send_fields(16'h0001, 16'h0001, F32_ONE, F32_ONE, 1'b0);           // subnormal inputs
    send_fields(16'h007F, 16'h8001, 32'h00000001, 32'h007FFFFF, 1'b1);
    send_fields(16'h0080, 16'h0000, 32'h3E800000, 32'h0, 1'b0);        // underflow to subnormal
    send_fields(BF_MAX, BF_MAX, F32_ONE, F32_NEG_ONE, 1'b0);           // FP32 overflow
    send_fields(BF_MAX, 16'h0000, 32'h3F808000, 32'h0, 1'b1);          // BF16 rounding overflow
    send_fields(16'hFF7F, 16'h0000, 32'h3F808000, 32'h0, 1'b0);
    send_fields(BF_MAX, 16'h0000, F32_ONE, 32'h0, 1'b0);
    send_fields(16'h3F81, 16'h3F80, 32'h3F7FFFFF, 32'h33800000, 1'b1); // rounding ties
    send_fields(16'h3F80, 16'h3F80, 32'h3F3504F3, 32'h3F3504F3, 1'b0);
    send_fields(16'h3F80, 16'h3F80, 32'h7F7FFFFF, 32'h7F7FFFFF, 1'b1); // exact cancellation
    send_fields(16'h4049, 16'hC049, 32'hBF800001, 32'h00800000, 1'b0);
    wait_drained();
  endtask

  // Realistic and odd operands mixed, with idling that changes per block of words.
  task automatic test_random_stream(input int count);
    rope_in_t w;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) begin
        tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 19;
        rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 19;
      end
      w.x_first   = pick_bf16();
      w.x_second  = pick_bf16();
      w.cos_bits  = pick_trig();
      w.sin_bits  = pick_trig();
      w.last_pair = ($urandom_range(0, 7) == 0);
      send_pair(w);
    end
  endtask

  // Sender holds off until the pipeline is empty, then sends a full-rate burst.
  task automatic test_drain_and_burst();
    tx_gap_max = 0; rx_gap_max = 3;
    wait_drained();
    repeat (30) send_fields(pick_bf16(), pick_bf16(), pick_trig(), pick_trig(), 1'($urandom));
    wait_drained();
  endtask

  // Result side: a random number of stall cycles ahead of each word.
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      gap = $urandom_range(0, rx_gap_max);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    rope_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_rot.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_data);
        fail_count++;
      end else begin
        want = pending_rot.pop_front();
        words_checked++;
        if (out_data.y_first !== want.y_first) begin
          $display("%0t: y_first expected %h actual %h", $time, want.y_first, out_data.y_first);
          fail_count++;
        end
        if (out_data.y_second !== want.y_second) begin
          $display("%0t: y_second expected %h actual %h", $time,
                   want.y_second, out_data.y_second);
          fail_count++;
        end
        if (out_data.last_out !== want.last_out) begin
          $display("%0t: last_out expected %b actual %b", $time,
                   want.last_out, out_data.last_out);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_stream(420);
    test_drain_and_burst();
    test_random_stream(400);
    wait_drained();
    repeat (20) @(posedge clk);
    $display("Rotated %0d pairs: special values, subnormals, overflow, ties, idle and stall mixes.",
             words_sent);
    $display("Checked %0d result words, %0d left unmatched.", words_checked, pending_rot.size());
    if (fail_count == 0 && pending_rot.size() == 0) begin
      $display("tb_rope_rotate_bf16 OK");
    end else begin
      $display("tb_rope_rotate_bf16 NOT OK");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_rope_rotate_bf16 NOT OK");
    $finish;
  end

endmodule

@@ files.f @@
sv/rope_pkg.sv
sv/rope_mul.sv
sv/rope_add.sv
sv/rope_rotate_bf16.sv
bench/tb_rope_rotate_bf16.sv
